>>> hw/rtl/bfr_pkg.sv
`timescale 1ns / 1ps

package bfr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ACC_WIDTH   = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int HELD_W      = 6;
    localparam int SHAMT_W     = 6;

    localparam logic [4:0]  MAX_GET_BITS    = 5'd24;
    localparam logic [11:0] SYNC_PATTERN_RST = 12'hFFF;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_GET   = 2'd1;
    localparam logic [1:0] CMD_SYNC  = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_GET,
        PEND_SYNC
    } pend_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GET_CHK,
        S_GET_FILL,
        S_SYNC_AL1,
        S_SYNC_AL2,
        S_SYNC_CHK,
        S_SYNC_FILL,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_GET_BYTE,
        OP_EXTRACT,
        OP_ALIGN_BYTE,
        OP_ALIGN_WINDOW,
        OP_SYNC_BYTE,
        OP_SYNC_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic [4:0]  nbits;
        logic [7:0]  din;
        logic [11:0] pattern;
    } dp_ctrl_t;

    typedef struct packed {
        logic [HELD_W-1:0] held;
        logic              match;
    } dp_stat_t;

endpackage

>>> hw/rtl/bfr_ram.sv
`timescale 1ns / 1ps

module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/bfr_datapath.sv
`timescale 1ns / 1ps

module bfr_datapath
    import bfr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  dp_ctrl_t      ctrl,
    output dp_stat_t      stat,
    output logic [23:0]   value
);

    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic [HELD_W-1:0]    held_reg, held_next;
    logic [ACC_WIDTH-1:0] shl_in, shl_out, shr_out;
    logic [SHAMT_W-1:0]   shl_amt, shr_amt;

    // Operand and amount selection for the shared shifters
    always_comb begin
        shl_in  = acc_reg;
        shl_amt = '0;
        shr_amt = '0;
        case (ctrl.op)
            OP_GET_BYTE: begin
                shl_in  = {24'd0, ctrl.din};
                shl_amt = SHAMT_W'(6'd24 - held_reg);
            end
            OP_EXTRACT: begin
                shl_amt = SHAMT_W'({1'b0, ctrl.nbits});
                shr_amt = SHAMT_W'(6'd32 - {1'b0, ctrl.nbits});
            end
            OP_ALIGN_BYTE:   shl_amt = SHAMT_W'(held_reg[2:0]);
            OP_ALIGN_WINDOW: shr_amt = SHAMT_W'(6'd32 - held_reg);
            OP_SYNC_BYTE:    shl_amt = SHAMT_W'(6'd8);
            OP_SYNC_DONE:    shl_amt = SHAMT_W'(6'd28);
            default: ;
        endcase
    end

    assign shl_out = shl_in << shl_amt;
    assign shr_out = acc_reg >> shr_amt;

    always_comb begin
        acc_next  = acc_reg;
        held_next = held_reg;
        case (ctrl.op)
            OP_CLEAR: begin
                acc_next  = '0;
                held_next = '0;
            end
            OP_GET_BYTE: begin
                acc_next  = acc_reg | shl_out;
                held_next = held_reg + HELD_W'(8);
            end
            OP_EXTRACT: begin
                acc_next  = shl_out;
                held_next = held_reg - HELD_W'({1'b0, ctrl.nbits});
            end
            OP_ALIGN_BYTE: begin
                acc_next  = shl_out;
                held_next = {held_reg[HELD_W-1:3], 3'b000};
            end
            OP_ALIGN_WINDOW: acc_next = shr_out;
            OP_SYNC_BYTE:    acc_next = {shl_out[ACC_WIDTH-1:8], ctrl.din};
            OP_SYNC_DONE: begin
                acc_next  = shl_out;
                held_next = HELD_W'(4);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            held_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            held_reg <= held_next;
        end
    end

    assign stat.held  = held_reg;
    assign stat.match = ((acc_reg[15:4] & ctrl.pattern) == ctrl.pattern);
    assign value      = shr_out[23:0];

endmodule

>>> hw/rtl/bit_field_reader_with_sync_hunt_unit.sv
`timescale 1ns / 1ps

// Bit-field reader with sync hunt. Each input word carries a command: push a
// stream byte into a 16-entry byte FIFO, get 1 to 24 bits (MSB first, counts
// above 24 saturate, zero returns zero at once), hunt for the sync word, or
// flush. The hunt drops bits to a byte boundary, then shifts in bytes until
// the bits set in sync_pattern are all ones in window bits 15..4; the low
// nibble stays behind as the next four bits. A request short of data stays
// pending and completes on a later push; a second request meanwhile is
// rejected as busy, and a push into a full FIFO returns an overflow word.
// Timing: the block takes one word at a time and is not ready while it works.
// A flush, or a push that resumes nothing, gives no result word. A get
// alternates check and fetch until enough bits are held; a hunt aligns first,
// then alternates them over up to 16 queued bytes. A check state reads a byte
// from the registered read port of the FIFO memory; a fill state shifts it in.
// The next word is taken while a finished result still waits on m_ready.

module bit_field_reader_with_sync_hunt_unit
    import bfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    // request words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_data_byte,
    input  logic [4:0]  s_bit_count,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_field_value,
    output logic [1:0]  m_status,
    output logic        m_sync_found
);

    state_t              state_reg, state_next;
    pend_t               pend_reg, pend_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [4:0]          nbits_reg, nbits_next;
    logic [11:0]         pattern_reg;
    logic [23:0]         res_value_reg, res_value_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                res_found_reg, res_found_next;
    logic                m_valid_reg, m_valid_next;
    logic [23:0]         m_value_reg;
    logic [1:0]          m_status_reg;
    logic                m_found_reg;
    logic                out_load;

    logic                ram_we, ram_re;
    logic [7:0]          ram_rdata;
    dp_ctrl_t            dp_ctrl;
    dp_stat_t            dp_stat;
    logic [23:0]         dp_value;
    logic                s_fire;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    // Byte FIFO storage
    bfr_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (s_data_byte),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Accumulator and the shared shift unit
    bfr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dp_ctrl),
        .stat    (dp_stat),
        .value   (dp_value)
    );

    // Sequencer: next state, queue bookkeeping and datapath commands
    always_comb begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        fill_next       = fill_reg;
        nbits_next      = nbits_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        out_load        = 1'b0;
        dp_ctrl.op      = OP_NONE;
        dp_ctrl.nbits   = nbits_reg;
        dp_ctrl.din     = ram_rdata;
        dp_ctrl.pattern = pattern_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    res_found_next  = 1'b0;
                    case (s_cmd)
                        CMD_FLUSH: begin
                            // drop everything but the sync pattern
                            dp_ctrl.op  = OP_CLEAR;
                            pend_next   = PEND_NONE;
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            fill_next   = '0;
                            nbits_next  = '0;
                        end
                        CMD_PUSH: begin
                            if (fill_reg == FILL_W'(QUEUE_DEPTH)) begin
                                res_status_next = ST_OVF;
                                state_next      = S_DONE;
                            end else begin
                                ram_we      = 1'b1;
                                wr_ptr_next = ptr_inc(wr_ptr_reg);
                                fill_next   = fill_reg + FILL_W'(1);
                                // retry whatever was waiting on data
                                if (pend_reg == PEND_GET) begin
                                    state_next = S_GET_CHK;
                                end else if (pend_reg == PEND_SYNC) begin
                                    state_next = S_SYNC_CHK;
                                end
                            end
                        end
                        default: begin
                            if (pend_reg != PEND_NONE) begin
                                res_status_next = ST_BUSY;
                                state_next      = S_DONE;
                            end else if (s_cmd == CMD_GET) begin
                                if (s_bit_count == 5'd0) begin
                                    state_next = S_DONE;
                                end else begin
                                    nbits_next = (s_bit_count > MAX_GET_BITS) ?
                                                 MAX_GET_BITS : s_bit_count;
                                    state_next = S_GET_CHK;
                                end
                            end else begin
                                state_next = S_SYNC_AL1;
                            end
                        end
                    endcase
                end
            end

            S_GET_CHK: begin
                if (dp_stat.held >= HELD_W'(nbits_reg)) begin
                    dp_ctrl.op     = OP_EXTRACT;
                    res_value_next = dp_value;
                    pend_next      = PEND_NONE;
                    nbits_next     = '0;
                    state_next     = S_DONE;
                end else if (fill_reg != '0) begin
                    ram_re      = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    fill_next   = fill_reg - FILL_W'(1);
                    state_next  = S_GET_FILL;
                end else begin
                    pend_next  = PEND_GET;
                    state_next = S_IDLE;
                end
            end

            S_GET_FILL: begin
                dp_ctrl.op = OP_GET_BYTE;
                state_next = S_GET_CHK;
            end

            S_SYNC_AL1: begin
                dp_ctrl.op = OP_ALIGN_BYTE;
                state_next = S_SYNC_AL2;
            end

            S_SYNC_AL2: begin
                dp_ctrl.op = OP_ALIGN_WINDOW;
                state_next = S_SYNC_CHK;
            end

            S_SYNC_CHK: begin
                if (dp_stat.match) begin
                    dp_ctrl.op     = OP_SYNC_DONE;
                    res_found_next = 1'b1;
                    pend_next      = PEND_NONE;
                    state_next     = S_DONE;
                end else if (fill_reg != '0) begin
                    ram_re      = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    fill_next   = fill_reg - FILL_W'(1);
                    state_next  = S_SYNC_FILL;
                end else begin
                    pend_next  = PEND_SYNC;
                    state_next = S_IDLE;
                end
            end

            S_SYNC_FILL: begin
                dp_ctrl.op = OP_SYNC_BYTE;
                state_next = S_SYNC_CHK;
            end

            S_DONE: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= PEND_NONE;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            fill_reg    <= '0;
            nbits_reg   <= '0;
            pattern_reg <= SYNC_PATTERN_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            fill_reg    <= fill_next;
            nbits_reg   <= nbits_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                pattern_reg <= cfg_wr_data;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge aclk) begin
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        if (out_load) begin
            m_value_reg  <= res_value_reg;
            m_status_reg <= res_status_reg;
            m_found_reg  <= res_found_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_field_value = m_value_reg;
    assign m_status      = m_status_reg;
    assign m_sync_found  = m_found_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("byte FIFO fill count above depth");

    a_pending_starved: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && pend_reg != PEND_NONE) |-> (fill_reg == '0))
        else $error("request left pending with bytes still queued");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_cmd == CMD_FLUSH) |=> (fill_reg == '0 && pend_reg == PEND_NONE))
        else $error("flush left queue or pending request behind");

    a_sync_word_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sync_found) |-> (m_field_value == '0 && m_status == ST_OK))
        else $error("sync result carries a value or a bad status");
`endif

endmodule
